@@ src/ahds_pkg.sv @@
// Shared constants, codes and control types of the allreduce schedule generator.
package ahds_pkg;

    // Largest communicator the block accepts
    localparam int MAX_PROCS = 1024;

    // Field widths
    localparam int RANK_W     = 10;
    localparam int PROCS_W    = 11;
    localparam int CNT_W      = 31;
    localparam int KIND_W     = 3;
    localparam int LVL_W      = 4;
    localparam int IDX_W      = PROCS_W;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = PROCS_W;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MY_RANK   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_PROCS = 1'b1;

    // Operation codes of a result
    typedef enum logic [KIND_W-1:0] {
        OP_DONE        = 3'd0,
        OP_ERROR       = 3'd1,
        OP_FOLD_SEND   = 3'd2,
        OP_FOLD_RECV   = 3'd3,
        OP_SCATTER     = 3'd4,
        OP_GATHER      = 3'd5,
        OP_UNFOLD_SEND = 3'd6,
        OP_UNFOLD_RECV = 3'd7
    } op_kind_t;

    // Controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_FOLD,
        ST_SC_IDX,
        ST_SC_MUL,
        ST_SC_FIN,
        ST_GA_IDX,
        ST_GA_MUL,
        ST_GA_FIN,
        ST_UNFOLD
    } state_t;

    // Which result the datapath loads into the output register
    typedef enum logic [2:0] {
        EM_NONE,
        EM_SPECIAL,
        EM_FOLD,
        EM_UNFOLD,
        EM_SCATTER,
        EM_GATHER
    } emit_t;

    // Controller to datapath
    typedef struct packed {
        logic  start;   // capture request and decode the setup
        logic  sc_idx;  // reduce-scatter block index update
        logic  ga_idx;  // allgather block index update
        logic  mul;     // block offset products
        emit_t emit;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic out_busy;  // output register holds a result that is not taken this cycle
        logic special;   // request answered by a single done or error result
        logic folded;    // rank takes part in the fold step
        logic rank_odd;
        logic scat_end;  // current step is the last halving step
        logic j_zero;    // current step is the last doubling step
    } dp_status_t;

endpackage

@@ src/allreduce_halving_doubling_schedule.sv @@
// Top level of the halving/doubling allreduce schedule generator.
//
// Usage: write my_rank (index 0) and num_procs (index 1) on the cfg channel while idle;
// cfg_ready is always high. Each transaction on the s_ channel carries one element count.
// The m_ channel then delivers this rank's schedule, one transaction per message operation:
// an optional fold, log2(pof2) halving and log2(pof2) doubling exchanges (none for an even
// folded rank) and an optional unfold, with m_last_op set on the final one. Zero counts,
// a single process, a bad configuration or a count below pof2 give one done or error
// transaction. Each exchange goes through an index update, an offset multiply and a result
// subtract, using one shared set of offset multipliers. s_ready is high only between
// requests.
// Reset: registers return to my_rank 0, num_procs 1 and no result is pending.
// Stall: results sit in an output register; the sequencer keeps computing the next
// operation and then holds until m_ready takes the waiting one. The next request is
// accepted while the last result of the previous one still waits.
module allreduce_halving_doubling_schedule (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [ahds_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ahds_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [ahds_pkg::CNT_W-1:0]       s_element_count,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [ahds_pkg::KIND_W-1:0]      m_op_kind,
    output logic [ahds_pkg::RANK_W-1:0]      m_peer_rank,
    output logic [ahds_pkg::CNT_W-1:0]       m_send_offset,
    output logic [ahds_pkg::CNT_W-1:0]       m_send_count,
    output logic [ahds_pkg::CNT_W-1:0]       m_recv_offset,
    output logic [ahds_pkg::CNT_W-1:0]       m_recv_count,
    output logic                             m_last_op
);

    ahds_pkg::dp_cmd_t    cmd;
    ahds_pkg::dp_status_t status;

    // Register writes are always taken
    assign cfg_ready = 1'b1;

    // Sequencer
    ahds_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // Datapath
    ahds_dp u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_element_count (s_element_count),
        .cmd             (cmd),
        .status          (status),
        .m_ready         (m_ready),
        .m_valid         (m_valid),
        .m_op_kind       (m_op_kind),
        .m_peer_rank     (m_peer_rank),
        .m_send_offset   (m_send_offset),
        .m_send_count    (m_send_count),
        .m_recv_offset   (m_recv_offset),
        .m_recv_count    (m_recv_count),
        .m_last_op       (m_last_op)
    );

endmodule

@@ src/ahds_ctrl.sv @@
// Schedule sequencer: walks fold, halving, doubling and unfold steps of one request.
module ahds_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  ahds_pkg::dp_status_t  status,
    output ahds_pkg::dp_cmd_t     cmd
);

    ahds_pkg::state_t state_reg;
    ahds_pkg::state_t state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ahds_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and datapath commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ahds_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.start  = 1'b1;
                    state_next = ahds_pkg::ST_CHECK;
                end
            end
            ahds_pkg::ST_CHECK: begin
                if (status.special) begin
                    if (!status.out_busy) begin
                        cmd.emit   = ahds_pkg::EM_SPECIAL;
                        state_next = ahds_pkg::ST_IDLE;
                    end
                end else if (status.folded) begin
                    state_next = ahds_pkg::ST_FOLD;
                end else begin
                    state_next = ahds_pkg::ST_SC_IDX;
                end
            end
            ahds_pkg::ST_FOLD: begin
                if (!status.out_busy) begin
                    cmd.emit   = ahds_pkg::EM_FOLD;
                    state_next = status.rank_odd ? ahds_pkg::ST_SC_IDX : ahds_pkg::ST_UNFOLD;
                end
            end
            ahds_pkg::ST_SC_IDX: begin
                cmd.sc_idx = 1'b1;
                state_next = ahds_pkg::ST_SC_MUL;
            end
            ahds_pkg::ST_SC_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ahds_pkg::ST_SC_FIN;
            end
            ahds_pkg::ST_SC_FIN: begin
                if (!status.out_busy) begin
                    cmd.emit   = ahds_pkg::EM_SCATTER;
                    state_next = status.scat_end ? ahds_pkg::ST_GA_IDX : ahds_pkg::ST_SC_IDX;
                end
            end
            ahds_pkg::ST_GA_IDX: begin
                cmd.ga_idx = 1'b1;
                state_next = ahds_pkg::ST_GA_MUL;
            end
            ahds_pkg::ST_GA_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ahds_pkg::ST_GA_FIN;
            end
            ahds_pkg::ST_GA_FIN: begin
                if (!status.out_busy) begin
                    cmd.emit = ahds_pkg::EM_GATHER;
                    if (!status.j_zero) begin
                        state_next = ahds_pkg::ST_GA_IDX;
                    end else if (status.folded) begin
                        state_next = ahds_pkg::ST_UNFOLD;
                    end else begin
                        state_next = ahds_pkg::ST_IDLE;
                    end
                end
            end
            ahds_pkg::ST_UNFOLD: begin
                if (!status.out_busy) begin
                    cmd.emit   = ahds_pkg::EM_UNFOLD;
                    state_next = ahds_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = ahds_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

@@ src/ahds_dp.sv @@
// Datapath: configuration registers, setup decode, block index and offset math, output register.
module ahds_dp (
    input  logic                             aclk,
    input  logic                             aresetn,
    // configuration writes
    input  logic                             cfg_valid,
    input  logic [ahds_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ahds_pkg::CFG_DATA_W-1:0]  cfg_data,
    // request
    input  logic [ahds_pkg::CNT_W-1:0]       s_element_count,
    // control
    input  ahds_pkg::dp_cmd_t                cmd,
    output ahds_pkg::dp_status_t             status,
    // result
    input  logic                             m_ready,
    output logic                             m_valid,
    output logic [ahds_pkg::KIND_W-1:0]      m_op_kind,
    output logic [ahds_pkg::RANK_W-1:0]      m_peer_rank,
    output logic [ahds_pkg::CNT_W-1:0]       m_send_offset,
    output logic [ahds_pkg::CNT_W-1:0]       m_send_count,
    output logic [ahds_pkg::CNT_W-1:0]       m_recv_offset,
    output logic [ahds_pkg::CNT_W-1:0]       m_recv_count,
    output logic                             m_last_op
);

    localparam int RANK_W = ahds_pkg::RANK_W;
    localparam int PROCS_W = ahds_pkg::PROCS_W;
    localparam int CNT_W = ahds_pkg::CNT_W;
    localparam int LVL_W = ahds_pkg::LVL_W;
    localparam int IDX_W = ahds_pkg::IDX_W;

    // Offset of block idx: idx*q + min(idx, r); never exceeds the element count
    function automatic logic [CNT_W-1:0] blk_off(input logic [IDX_W-1:0] idx,
                                                  input logic [CNT_W-1:0] q,
                                                  input logic [RANK_W-1:0] r);
        logic [IDX_W+CNT_W-1:0] prod;
        logic [IDX_W-1:0]       mn;
        prod = {{CNT_W{1'b0}}, idx} * {{IDX_W{1'b0}}, q};
        mn   = (idx < {1'b0, r}) ? idx : {1'b0, r};
        return prod[CNT_W-1:0] + {{(CNT_W-IDX_W){1'b0}}, mn};
    endfunction

    // Configuration registers
    logic [RANK_W-1:0]  my_rank_reg;
    logic [PROCS_W-1:0] num_procs_reg;

    // Per-request setup
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      q_reg;
    logic [RANK_W-1:0]     r_reg;
    logic [LVL_W-1:0]      lvl_reg;
    logic [IDX_W-1:0]      pof2_reg;
    logic [RANK_W-1:0]     rem_reg;
    logic [RANK_W-1:0]     newrank_reg;
    logic                  folded_reg;
    logic                  spec_reg;
    ahds_pkg::op_kind_t    spec_kind_reg;

    // Step state
    logic [LVL_W-1:0]  j_reg;
    logic [IDX_W-1:0]  sidx_reg;
    logic [IDX_W-1:0]  ridx_reg;
    logic [IDX_W-1:0]  lidx_reg;
    logic [RANK_W-1:0] peer_reg;
    logic [CNT_W-1:0]  off_s_reg;
    logic [CNT_W-1:0]  off_r_reg;
    logic [CNT_W-1:0]  off_l_reg;

    // Output register
    logic               m_valid_reg;
    ahds_pkg::op_kind_t op_kind_reg;
    logic [RANK_W-1:0]  peer_rank_reg;
    logic [CNT_W-1:0]   send_offset_reg;
    logic [CNT_W-1:0]   send_count_reg;
    logic [CNT_W-1:0]   recv_offset_reg;
    logic [CNT_W-1:0]   recv_count_reg;
    logic               last_op_reg;

    // Setup decode
    logic [LVL_W-1:0]   lvl;
    logic [IDX_W-1:0]   pof2;
    logic               invalid;
    logic [RANK_W-1:0]  rem;
    logic               folded;
    logic [RANK_W-1:0]  newrank;
    logic [CNT_W-1:0]   quot;
    logic [RANK_W-1:0]  remd;
    logic               spec;
    ahds_pkg::op_kind_t spec_kind;

    // Step decode
    logic [IDX_W-1:0]  half;
    logic [RANK_W-1:0] nd;
    logic [RANK_W-1:0] peer;
    logic              nb;
    logic [RANK_W-1:0] fold_peer;

    always_comb begin
        lvl = '0;
        for (int b = 0; b < PROCS_W; b++) begin
            if (num_procs_reg[b]) begin
                lvl = LVL_W'(b);
            end
        end
        pof2    = IDX_W'(1) << lvl;
        invalid = (num_procs_reg == '0) ||
                  (num_procs_reg > PROCS_W'(ahds_pkg::MAX_PROCS)) ||
                  ({1'b0, my_rank_reg} >= num_procs_reg);
        rem     = RANK_W'(num_procs_reg - pof2);
        folded  = {1'b0, my_rank_reg} < {rem, 1'b0};
        newrank = folded ? (my_rank_reg >> 1) : (my_rank_reg - rem);
        quot    = s_element_count >> lvl;
        remd    = s_element_count[RANK_W-1:0] & RANK_W'(pof2 - IDX_W'(1));

        // special answers, in order of precedence
        spec      = 1'b1;
        spec_kind = ahds_pkg::OP_DONE;
        priority if (s_element_count == '0) begin
            spec_kind = ahds_pkg::OP_DONE;
        end else if (invalid) begin
            spec_kind = ahds_pkg::OP_ERROR;
        end else if (num_procs_reg == PROCS_W'(1)) begin
            spec_kind = ahds_pkg::OP_DONE;
        end else if (s_element_count < CNT_W'(pof2)) begin
            spec_kind = ahds_pkg::OP_ERROR;
        end else begin
            spec = 1'b0;
        end
    end

    always_comb begin
        half      = pof2_reg >> (j_reg + LVL_W'(1));
        nd        = newrank_reg ^ (RANK_W'(1) << j_reg);
        peer      = (nd < rem_reg) ? RANK_W'({nd, 1'b1}) : (nd + rem_reg);
        nb        = newrank_reg[j_reg];
        fold_peer = my_rank_reg[0] ? (my_rank_reg - RANK_W'(1)) : (my_rank_reg + RANK_W'(1));
    end

    assign status.out_busy = m_valid_reg && !m_ready;
    assign status.special  = spec_reg;
    assign status.folded   = folded_reg;
    assign status.rank_odd = my_rank_reg[0];
    assign status.scat_end = (j_reg + LVL_W'(1)) == lvl_reg;
    assign status.j_zero   = (j_reg == '0);

    // Configuration and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            my_rank_reg   <= '0;
            num_procs_reg <= PROCS_W'(1);
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    ahds_pkg::REG_MY_RANK:   my_rank_reg   <= cfg_data[RANK_W-1:0];
                    ahds_pkg::REG_NUM_PROCS: num_procs_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.emit != ahds_pkg::EM_NONE) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Setup capture, index updates, offset products and result formation
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            count_reg     <= s_element_count;
            q_reg         <= quot;
            r_reg         <= remd;
            lvl_reg       <= lvl;
            pof2_reg      <= pof2;
            rem_reg       <= rem;
            newrank_reg   <= newrank;
            folded_reg    <= folded;
            spec_reg      <= spec;
            spec_kind_reg <= spec_kind;
            j_reg         <= '0;
            sidx_reg      <= '0;
            ridx_reg      <= '0;
            lidx_reg      <= pof2;
        end

        // halving step: the half this rank keeps moves its bound
        if (cmd.sc_idx) begin
            peer_reg <= peer;
            if (!nb) begin
                sidx_reg <= ridx_reg + half;
            end else begin
                ridx_reg <= sidx_reg + half;
            end
        end

        // doubling step
        if (cmd.ga_idx) begin
            peer_reg <= peer;
            if (!nb) begin
                if (j_reg != (lvl_reg - LVL_W'(1))) begin
                    lidx_reg <= lidx_reg + half;
                end
                ridx_reg <= sidx_reg + half;
            end else begin
                ridx_reg <= sidx_reg - half;
            end
        end

        if (cmd.mul) begin
            off_s_reg <= blk_off(sidx_reg, q_reg, r_reg);
            off_r_reg <= blk_off(ridx_reg, q_reg, r_reg);
            off_l_reg <= blk_off(lidx_reg, q_reg, r_reg);
        end

        unique case (cmd.emit)
            ahds_pkg::EM_NONE: ;
            ahds_pkg::EM_SPECIAL: begin
                op_kind_reg     <= spec_kind_reg;
                peer_rank_reg   <= '0;
                send_offset_reg <= '0;
                send_count_reg  <= '0;
                recv_offset_reg <= '0;
                recv_count_reg  <= '0;
                last_op_reg     <= 1'b1;
            end
            ahds_pkg::EM_FOLD: begin
                op_kind_reg     <= my_rank_reg[0] ? ahds_pkg::OP_FOLD_RECV
                                                  : ahds_pkg::OP_FOLD_SEND;
                peer_rank_reg   <= fold_peer;
                send_offset_reg <= '0;
                send_count_reg  <= my_rank_reg[0] ? '0 : count_reg;
                recv_offset_reg <= '0;
                recv_count_reg  <= my_rank_reg[0] ? count_reg : '0;
                last_op_reg     <= 1'b0;
            end
            ahds_pkg::EM_UNFOLD: begin
                op_kind_reg     <= my_rank_reg[0] ? ahds_pkg::OP_UNFOLD_SEND
                                                  : ahds_pkg::OP_UNFOLD_RECV;
                peer_rank_reg   <= fold_peer;
                send_offset_reg <= '0;
                send_count_reg  <= my_rank_reg[0] ? count_reg : '0;
                recv_offset_reg <= '0;
                recv_count_reg  <= my_rank_reg[0] ? '0 : count_reg;
                last_op_reg     <= 1'b1;
            end
            ahds_pkg::EM_SCATTER: begin
                op_kind_reg     <= ahds_pkg::OP_SCATTER;
                peer_rank_reg   <= peer_reg;
                send_offset_reg <= off_s_reg;
                recv_offset_reg <= off_r_reg;
                if (!nb) begin
                    send_count_reg <= off_l_reg - off_s_reg;
                    recv_count_reg <= off_s_reg - off_r_reg;
                end else begin
                    send_count_reg <= off_r_reg - off_s_reg;
                    recv_count_reg <= off_l_reg - off_r_reg;
                end
                last_op_reg <= 1'b0;
                // next step starts from the received half
                sidx_reg <= ridx_reg;
                if ((j_reg + LVL_W'(1)) != lvl_reg) begin
                    j_reg    <= j_reg + LVL_W'(1);
                    lidx_reg <= ridx_reg + half;
                end
            end
            ahds_pkg::EM_GATHER: begin
                op_kind_reg     <= ahds_pkg::OP_GATHER;
                peer_rank_reg   <= peer_reg;
                send_offset_reg <= off_s_reg;
                recv_offset_reg <= off_r_reg;
                if (!nb) begin
                    send_count_reg <= off_r_reg - off_s_reg;
                    recv_count_reg <= off_l_reg - off_r_reg;
                end else begin
                    send_count_reg <= off_l_reg - off_s_reg;
                    recv_count_reg <= off_s_reg - off_r_reg;
                    sidx_reg       <= ridx_reg;
                end
                last_op_reg <= (j_reg == '0) && !folded_reg;
                if (j_reg != '0) begin
                    j_reg <= j_reg - LVL_W'(1);
                end
            end
            default: ;
        endcase
    end

    assign m_valid       = m_valid_reg;
    assign m_op_kind     = op_kind_reg;
    assign m_peer_rank   = peer_rank_reg;
    assign m_send_offset = send_offset_reg;
    assign m_send_count  = send_count_reg;
    assign m_recv_offset = recv_offset_reg;
    assign m_recv_count  = recv_count_reg;
    assign m_last_op     = last_op_reg;

endmodule

@@ src/ahds_checker.sv @@
// Port-level checks of the schedule generator, bound to the top level.
module ahds_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_valid,
    input logic                             s_ready,
    input logic                             m_valid,
    input logic                             m_ready,
    input logic [ahds_pkg::KIND_W-1:0]      m_op_kind,
    input logic [ahds_pkg::RANK_W-1:0]      m_peer_rank,
    input logic [ahds_pkg::CNT_W-1:0]       m_send_offset,
    input logic [ahds_pkg::CNT_W-1:0]       m_send_count,
    input logic [ahds_pkg::CNT_W-1:0]       m_recv_offset,
    input logic [ahds_pkg::CNT_W-1:0]       m_recv_count,
    input logic                             m_last_op
);

    // No result pending right after reset
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // A stalled result holds its payload
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_op_kind) && $stable(m_peer_rank) &&
            $stable(m_send_offset) && $stable(m_send_count) && $stable(m_recv_offset) &&
            $stable(m_recv_count) && $stable(m_last_op)))
        else $error("stalled result changed");

    // One request at a time: no new request right after one is taken
    a_one_request: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("request accepted while busy");

    // A pending result that is not the last one keeps the request side closed
    a_mid_schedule: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_last_op) |-> !s_ready)
        else $error("request accepted in the middle of a schedule");

    // Done and error answers are single, empty results
    a_special_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_op_kind == ahds_pkg::OP_DONE || m_op_kind == ahds_pkg::OP_ERROR)) |->
            (m_last_op && m_peer_rank == '0 && m_send_count == '0 && m_recv_count == '0 &&
             m_send_offset == '0 && m_recv_offset == '0))
        else $error("malformed done or error result");

endmodule

bind allreduce_halving_doubling_schedule ahds_checker u_ahds_checker (.*);

@@ tb/tb.sv @@
// Self-checking testbench for the halving/doubling allreduce schedule generator.
`timescale 1ns / 1ps

module tb;
    import ahds_pkg::*;

    localparam int unsigned LIMIT_CYCLES = 2_000_000;
    localparam int          ITEM_TARGET  = 420;
    localparam int          TAIL_CYCLES  = 64;

    // One schedule entry as seen on the m_ channel
    typedef struct packed {
        op_kind_t          kind;
        logic [RANK_W-1:0] peer;
        logic [CNT_W-1:0]  send_off;
        logic [CNT_W-1:0]  send_len;
        logic [CNT_W-1:0]  recv_off;
        logic [CNT_W-1:0]  recv_len;
        logic              last_op;
    } sched_op_t;

    // Predicts each request's schedule and checks the results in order
    class schedule_scoreboard;
        sched_op_t           expected_ops[$];
        logic [RANK_W-1:0]   rank_reg;
        logic [PROCS_W-1:0]  procs_reg;
        longint unsigned     blk_q;
        longint unsigned     blk_r;
        int                  mismatches;

        function new();
            rank_reg   = '0;
            procs_reg  = 1;
            mismatches = 0;
        endfunction

        static function longint unsigned pow2_floor(longint unsigned p);
            longint unsigned v;
            v = 1;
            while (v * 2 <= p)
                v = v << 1;
            return v;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == REG_MY_RANK) begin
                rank_reg = data[RANK_W-1:0];
            end else begin
                procs_reg = data;
            end
        endfunction

        function int outstanding();
            return expected_ops.size();
        endfunction

        // First element of block i; the remainder goes to the low blocks
        function longint unsigned block_start(longint unsigned i);
            return i * blk_q + ((i < blk_r) ? i : blk_r);
        endfunction

        // Real rank of a partner given its rank among the active set
        function longint unsigned peer_of(longint unsigned nd, longint unsigned rem);
            return (nd < rem) ? nd * 2 + 1 : nd + rem;
        endfunction

        function void add_op(op_kind_t kind, longint unsigned peer,
                             longint unsigned so, longint unsigned sc,
                             longint unsigned ro, longint unsigned rc);
            sched_op_t op;
            op.kind     = kind;
            op.peer     = peer[RANK_W-1:0];
            op.send_off = so[CNT_W-1:0];
            op.send_len = sc[CNT_W-1:0];
            op.recv_off = ro[CNT_W-1:0];
            op.recv_len = rc[CNT_W-1:0];
            op.last_op  = 1'b0;
            expected_ops.push_back(op);
        endfunction

        function void note_request(logic [CNT_W-1:0] count);
            longint unsigned cnt, p, rank, pof2, rem, newrank;
            longint unsigned mask, sidx, ridx, lidx, nd, half, sc, rc;
            bit              folded;
            sched_op_t       tail;
            cnt     = 64'(count);
            p       = 64'(procs_reg);
            rank    = 64'(rank_reg);
            newrank = 0;
            if (cnt == 0) begin
                add_op(OP_DONE, 0, 0, 0, 0, 0);
            end else if (p == 0 || p > MAX_PROCS || rank >= p) begin
                add_op(OP_ERROR, 0, 0, 0, 0, 0);
            end else if (p == 1) begin
                add_op(OP_DONE, 0, 0, 0, 0, 0);
            end else begin
                pof2 = pow2_floor(p);
                if (cnt < pof2) begin
                    add_op(OP_ERROR, 0, 0, 0, 0, 0);
                end else begin
                    rem    = p - pof2;
                    blk_q  = cnt / pof2;
                    blk_r  = cnt % pof2;
                    folded = (rank < 2 * rem);
                    if (folded && !rank[0]) begin
                        // even excess rank hands everything over and sits out
                        add_op(OP_FOLD_SEND, rank + 1, 0, cnt, 0, 0);
                    end else begin
                        if (folded) begin
                            add_op(OP_FOLD_RECV, rank - 1, 0, 0, 0, cnt);
                            newrank = rank >> 1;
                        end else begin
                            newrank = rank - rem;
                        end
                        // reduce-scatter by recursive halving
                        mask = 1;
                        sidx = 0;
                        ridx = 0;
                        lidx = pof2;
                        while (mask < pof2) begin
                            nd   = newrank ^ mask;
                            half = pof2 / (mask * 2);
                            if (newrank < nd) begin
                                sidx = ridx + half;
                                sc   = block_start(lidx) - block_start(sidx);
                                rc   = block_start(sidx) - block_start(ridx);
                            end else begin
                                ridx = sidx + half;
                                sc   = block_start(ridx) - block_start(sidx);
                                rc   = block_start(lidx) - block_start(ridx);
                            end
                            add_op(OP_SCATTER, peer_of(nd, rem), block_start(sidx), sc,
                                   block_start(ridx), rc);
                            sidx = ridx;
                            mask = mask << 1;
                            if (mask < pof2)
                                lidx = ridx + pof2 / mask;
                        end
                        // allgather by recursive doubling
                        mask = mask >> 1;
                        while (mask > 0) begin
                            nd   = newrank ^ mask;
                            half = pof2 / (mask * 2);
                            if (newrank < nd) begin
                                if (mask != pof2 / 2)
                                    lidx = lidx + half;
                                ridx = sidx + half;
                                sc   = block_start(ridx) - block_start(sidx);
                                rc   = block_start(lidx) - block_start(ridx);
                            end else begin
                                ridx = sidx - half;
                                sc   = block_start(lidx) - block_start(sidx);
                                rc   = block_start(sidx) - block_start(ridx);
                            end
                            add_op(OP_GATHER, peer_of(nd, rem), block_start(sidx), sc,
                                   block_start(ridx), rc);
                            if (newrank > nd)
                                sidx = ridx;
                            mask = mask >> 1;
                        end
                    end
                    // pairs unfold at the end
                    if (folded) begin
                        if (rank[0])
                            add_op(OP_UNFOLD_SEND, rank - 1, 0, cnt, 0, 0);
                        else
                            add_op(OP_UNFOLD_RECV, rank + 1, 0, 0, 0, cnt);
                    end
                end
            end
            tail = expected_ops.pop_back();
            tail.last_op = 1'b1;
            expected_ops.push_back(tail);
        endfunction

        function string fmt(sched_op_t op);
            return $sformatf("kind %0d peer %0d send %0d+%0d recv %0d+%0d last %0d",
                             op.kind, op.peer, op.send_off, op.send_len,
                             op.recv_off, op.recv_len, op.last_op);
        endfunction

        function void check_op(sched_op_t got);
            sched_op_t want;
            if (expected_ops.size() == 0) begin
                if (mismatches < 10)
                    $display("%0t: unexpected result: %s", $realtime, fmt(got));
                mismatches++;
                return;
            end
            want = expected_ops.pop_front();
            if (got.kind !== want.kind || got.peer !== want.peer ||
                got.send_off !== want.send_off || got.send_len !== want.send_len ||
                got.recv_off !== want.recv_off || got.recv_len !== want.recv_len ||
                got.last_op !== want.last_op) begin
                if (mismatches < 10) begin
                    $display("%0t: result mismatch", $realtime);
                    $display("  expected %s", fmt(want));
                    $display("  actual   %s", fmt(got));
                end
                mismatches++;
            end
        endfunction
    endclass

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   s_valid;
    logic                   s_ready;
    logic [CNT_W-1:0]       s_element_count;
    logic                   m_valid;
    logic                   m_ready;
    logic [KIND_W-1:0]      m_op_kind;
    logic [RANK_W-1:0]      m_peer_rank;
    logic [CNT_W-1:0]       m_send_offset;
    logic [CNT_W-1:0]       m_send_count;
    logic [CNT_W-1:0]       m_recv_offset;
    logic [CNT_W-1:0]       m_recv_count;
    logic                   m_last_op;

    schedule_scoreboard sb = new();
    bit                 tx_steady = 1'b0;
    bit                 rx_steady = 1'b0;
    int                 items_sent = 0;

    allreduce_halving_doubling_schedule dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_element_count (s_element_count),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_op_kind       (m_op_kind),
        .m_peer_rank     (m_peer_rank),
        .m_send_offset   (m_send_offset),
        .m_send_count    (m_send_count),
        .m_recv_offset   (m_recv_offset),
        .m_recv_count    (m_recv_count),
        .m_last_op       (m_last_op)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Idle length: mostly none or short, now and then long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // Offer one element count and wait for the transaction
    task automatic send_request(input logic [CNT_W-1:0] count);
        int gap;
        gap = tx_steady ? 0 : idle_len();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_element_count <= count;
        do @(posedge aclk); while (!s_ready);
        sb.note_request(count);
        items_sent++;
    endtask

    // Hold off the sender until every predicted result is back
    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (sb.outstanding() != 0);
    endtask

    // Write both registers with the block idle
    task automatic apply_setting(input logic [CFG_DATA_W-1:0] rank_data,
                                 input logic [CFG_DATA_W-1:0] procs);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= REG_MY_RANK;
        cfg_data  <= rank_data;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(REG_MY_RANK, rank_data);
        cfg_index <= REG_NUM_PROCS;
        cfg_data  <= procs;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(REG_NUM_PROCS, procs);
        cfg_valid <= 1'b0;
    endtask

    // Result side: random backpressure and checking
    initial begin
        sched_op_t got;
        int        stall_left;
        stall_left = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                got.kind     = op_kind_t'(m_op_kind);
                got.peer     = m_peer_rank;
                got.send_off = m_send_offset;
                got.send_len = m_send_count;
                got.recv_off = m_recv_offset;
                got.recv_len = m_recv_count;
                got.last_op  = m_last_op;
                sb.check_op(got);
            end
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else if (rx_steady) begin
                m_ready <= 1'b1;
            end else begin
                stall_left = idle_len();
                m_ready <= (stall_left == 0);
                if (stall_left > 0)
                    stall_left--;
            end
        end
    end

    // Watchdog
    initial begin
        int unsigned cycles;
        cycles = 0;
        while (cycles < LIMIT_CYCLES) begin
            @(posedge aclk);
            cycles++;
        end
        $display("tb failed");
        $finish;
    end

    // Stimulus
    initial begin
        int                     r;
        int                     batch;
        longint unsigned        pof2;
        logic [CNT_W-1:0]       cnt;
        logic [CFG_DATA_W-1:0]  procs;
        logic [CFG_DATA_W-1:0]  rank_data;

        aresetn         <= 1'b0;
        cfg_valid       <= 1'b0;
        cfg_index       <= REG_MY_RANK;
        cfg_data        <= '0;
        s_valid         <= 1'b0;
        s_element_count <= '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // reset setting is a single process: zero count, small and full counts
        send_request(0);
        send_request(5);
        send_request(31'h7FFF_FFFF);

        // bad configurations: no processes, too many, rank out of range
        apply_setting(0, 0);
        send_request(1);
        send_request(0);
        apply_setting(0, 2047);
        send_request(100);
        apply_setting(0, 1025);
        send_request(4096);
        apply_setting(4, 4);
        send_request(50);

        // largest communicator, last rank: count below, at and far above pof2
        apply_setting(1023, 1024);
        send_request(1023);
        send_request(1024);
        send_request(31'h7FFF_FFFF);
        send_request(1025);

        // seven processes: even and odd folded ranks, active unfolded ranks
        apply_setting(0, 7);
        send_request(3);
        send_request(4);
        send_request(37);
        apply_setting(1, 7);
        send_request(1000);
        apply_setting(6, 7);
        send_request(29);

        // nearly full folding at 1023 processes
        apply_setting(1021, 1023);
        send_request(513);
        apply_setting(1022, 1023);
        send_request(31'h7FFF_FFFF);

        // two processes, rank field with its unused top bit set
        apply_setting(11'h401, 2);
        send_request(1);
        send_request(3);

        // random settings, each with a batch of mostly well-formed counts
        while (items_sent < ITEM_TARGET) begin
            r = $urandom_range(0, 99);
            if (r < 55)
                procs = CFG_DATA_W'($urandom_range(2, 16));
            else if (r < 75)
                procs = CFG_DATA_W'($urandom_range(17, 1024));
            else if (r < 83)
                procs = 1024;
            else if (r < 88)
                procs = 1;
            else if (r < 94)
                procs = CFG_DATA_W'($urandom_range(1025, 2047));
            else
                procs = 0;
            if ($urandom_range(0, 99) < 85 && procs != 0)
                rank_data = CFG_DATA_W'($urandom_range(0,
                                ((procs > 1024) ? 1023 : 32'(procs) - 1)));
            else
                rank_data = CFG_DATA_W'($urandom_range(0, 1023));
            if ($urandom_range(0, 9) == 0)
                rank_data[CFG_DATA_W-1] = 1'b1;
            apply_setting(rank_data, procs);

            tx_steady = ($urandom_range(0, 3) == 0);
            rx_steady = ($urandom_range(0, 3) == 0);
            pof2  = schedule_scoreboard::pow2_floor(64'(procs));
            batch = $urandom_range(8, 30);
            repeat (batch) begin
                if ($urandom_range(0, 19) == 0)
                    drain();
                r = $urandom_range(0, 99);
                if (r < 5)
                    cnt = 0;
                else if (r < 10 && pof2 > 1)
                    cnt = CNT_W'($urandom_range(32'(pof2 - 1), 1));
                else if (r < 20)
                    cnt = CNT_W'($urandom);
                else if (r < 23)
                    cnt = 31'h7FFF_FFFF;
                else
                    cnt = CNT_W'($urandom_range(32'(pof2 * 8 + 64), 32'(pof2)));
                send_request(cnt);
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (sb.mismatches == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
